### rtl/tcb_pkg.sv
`timescale 1ns / 1ps
package tcb_pkg;

  localparam int GRID_WIDTH  = 128;
  localparam int GRID_HEIGHT = 64;
  localparam int CELL_COUNT  = GRID_WIDTH * GRID_HEIGHT;
  localparam int CELL_ADDR_W = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int COL_W       = (GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1;
  localparam int ROW_W       = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;

  localparam logic [15:0] SPACE_CODE = 16'h0020;
  localparam logic [7:0]  ROW_MAX    = 8'hFF;

  localparam logic [2:0] CMD_SET_CELL = 3'd0;
  localparam logic [2:0] CMD_SET_CHAR = 3'd1;
  localparam logic [2:0] CMD_SET_ATTR = 3'd2;
  localparam logic [2:0] CMD_READ     = 3'd3;
  localparam logic [2:0] CMD_CLEAR    = 3'd4;
  localparam logic [2:0] CMD_SPRITE   = 3'd5;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        char_code;
    logic [15:0]        attr_value;
    logic [7:0]         sprite_width;
    logic               first_cell;
    logic               hurt;
  } item_t;

  typedef struct packed {
    logic [15:0] read_char;
    logic [15:0] read_attr;
    logic        was_inside;
  } result_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ
  } state_t;

  typedef struct packed {
    logic item_en;
    logic sweep_load;
    logic sweep_en;
  } ctrl_t;

  typedef struct packed {
    logic sweep_last;
  } status_t;

  function automatic logic [CELL_ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                       input logic [COL_W-1:0] col);
    cell_addr = CELL_ADDR_W'(row) * CELL_ADDR_W'(GRID_WIDTH) + CELL_ADDR_W'(col);
  endfunction

endpackage

### rtl/tcb_ctrl.sv
`timescale 1ns / 1ps
module tcb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [2:0]        command,
  input  tcb_pkg::status_t  status,
  output tcb_pkg::ctrl_t    ctrl,
  output logic              busy,
  output logic              done
);
  import tcb_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (status.sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          if (command == CMD_CLEAR) begin
            state_next = ST_CLEAR;
          end else if (command == CMD_READ) begin
            state_next = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl.item_en    = start && (state == ST_IDLE);
    ctrl.sweep_load = ctrl.item_en && (command == CMD_CLEAR);
    ctrl.sweep_en   = (state == ST_CLEAR);
    busy            = (state != ST_IDLE);
    done            = (state == ST_READ);
  end

endmodule

### rtl/tcb_datapath.sv
`timescale 1ns / 1ps
module tcb_datapath (
  input  logic              clk,
  input  logic              rst,
  input  tcb_pkg::item_t    item,
  input  tcb_pkg::ctrl_t    ctrl,
  output tcb_pkg::status_t  status,
  output tcb_pkg::result_t  result
);
  import tcb_pkg::*;

  logic [15:0] char_mem [CELL_COUNT];
  logic [15:0] attr_mem [CELL_COUNT];
  logic [15:0] char_q;
  logic [15:0] attr_q;
  logic        inside_q;

  logic [CELL_ADDR_W-1:0] sweep_cnt;
  logic [15:0]            fill_char;
  logic [15:0]            fill_attr;

  logic [7:0] sprite_col;
  logic [7:0] sprite_row;
  logic [7:0] col_base;
  logic [7:0] row_base;
  logic [8:0] col_inc;
  logic [7:0] width_eff;

  logic signed [17:0]     px;
  logic signed [17:0]     py;
  logic                   on_grid;
  logic [CELL_ADDR_W-1:0] item_addr;

  logic                   we_char;
  logic                   we_attr;
  logic [CELL_ADDR_W-1:0] waddr;
  logic [15:0]            wchar;
  logic [15:0]            wattr;

  logic is_sprite;

  // position: sprite cells add the running column/row offset
  always_comb begin
    is_sprite = (item.command == CMD_SPRITE);
    col_base  = item.first_cell ? 8'd0 : sprite_col;
    row_base  = item.first_cell ? 8'd0 : sprite_row;
    if (is_sprite) begin
      px = 18'(item.pos_x) + $signed({10'b0, col_base});
      py = 18'(item.pos_y) + $signed({10'b0, row_base});
    end else begin
      px = 18'(item.pos_x);
      py = 18'(item.pos_y);
    end
    on_grid = (px >= 0) && (px < GRID_WIDTH) && (py >= 0) && (py < GRID_HEIGHT);
    item_addr = cell_addr(py[ROW_W-1:0], px[COL_W-1:0]);
  end

  always_comb begin
    we_char = 1'b0;
    we_attr = 1'b0;
    waddr   = item_addr;
    wchar   = item.char_code;
    wattr   = item.attr_value;
    if (ctrl.sweep_en) begin
      we_char = 1'b1;
      we_attr = 1'b1;
      waddr   = sweep_cnt;
      wchar   = fill_char;
      wattr   = fill_attr;
    end else if (ctrl.item_en && on_grid) begin
      unique case (item.command)
        CMD_SET_CELL: begin
          we_char = 1'b1;
          we_attr = 1'b1;
        end
        CMD_SET_CHAR: we_char = 1'b1;
        CMD_SET_ATTR: we_attr = 1'b1;
        CMD_SPRITE: begin
          we_char = (item.char_code != SPACE_CODE);
          we_attr = (item.char_code != SPACE_CODE);
          if (item.hurt) wattr = ~item.attr_value;
        end
        default: begin
          we_char = 1'b0;
          we_attr = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we_char) char_mem[waddr] <= wchar;
    if (we_attr) attr_mem[waddr] <= wattr;
    if (ctrl.item_en) begin
      char_q   <= char_mem[item_addr];
      attr_q   <= attr_mem[item_addr];
      inside_q <= on_grid;
    end
  end

  // fill sweep, also run straight after reset with a zero fill
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
      fill_char <= '0;
      fill_attr <= '0;
    end else if (ctrl.sweep_load) begin
      sweep_cnt <= '0;
      fill_char <= item.char_code;
      fill_attr <= item.attr_value;
    end else if (ctrl.sweep_en) begin
      sweep_cnt <= sweep_cnt + 1'b1;
    end
  end

  assign status.sweep_last = (sweep_cnt == CELL_ADDR_W'(CELL_COUNT - 1));

  always_comb begin
    width_eff = (item.sprite_width == 8'd0) ? 8'd1 : item.sprite_width;
    col_inc   = {1'b0, col_base} + 9'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sprite_col <= '0;
      sprite_row <= '0;
    end else if (ctrl.item_en && is_sprite) begin
      if (col_inc >= {1'b0, width_eff}) begin
        sprite_col <= '0;
        sprite_row <= (row_base == ROW_MAX) ? ROW_MAX : row_base + 8'd1;
      end else begin
        sprite_col <= col_inc[7:0];
        sprite_row <= row_base;
      end
    end
  end

  always_comb begin
    result.was_inside = inside_q;
    result.read_char  = inside_q ? char_q : 16'd0;
    result.read_attr  = inside_q ? attr_q : 16'd0;
  end

endmodule

### rtl/text_cell_buffer_sprite_blit.sv
`timescale 1ns / 1ps
// character-cell framebuffer with a one-cell-per-item sprite blitter
// input: an item is taken at a rising edge where start is high and busy low;
//   command selects set cell, set char, set attr, read, clear or sprite cell
// output: a read gives one result on result, marked by done for one cycle,
//   in the cycle right after it was taken; the receiver has no way to hold it off
// timing: set, set char, set attr and sprite cells each make one write on the
//   cell memory port and leave the block idle, so back-to-back items are taken;
//   a read is the registered memory read plus the result cycle, with busy high in it
// clear: writes the whole grid of 8192 cells one cell a cycle, with busy high
// reset: the same sweep runs with a zero fill, so the block is busy after reset
//   until the whole grid is written; the sprite column and row counters start at zero
// writes that land off the grid are dropped; reads off the grid return zeros
module text_cell_buffer_sprite_blit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  tcb_pkg::item_t    item,
  output logic              done,
  output tcb_pkg::result_t  result
);
  import tcb_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  tcb_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (item.command),
    .status  (status),
    .ctrl    (ctrl),
    .busy    (busy),
    .done    (done)
  );

  tcb_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .ctrl   (ctrl),
    .status (status),
    .result (result)
  );

endmodule
